@@ sv/sdcr_pkg.sv @@
// Package for the SD card command responder.
// Holds codes, card-state encoding, reply structs and the CRC7 and CSD helpers.
// No dependencies.
package sdcr_pkg;

	localparam int unsigned REPLY_BYTES = 17;
	localparam logic [4:0] INIT_POLLS = 5'd20;
	localparam logic [31:0] CARD_SECTORS_RST = 32'd1048576;
	localparam logic [31:0] HC_LIMIT = 32'd4194304;
	localparam logic [15:0] RCA_VALUE = 16'd3;

	localparam logic [1:0] ACT_CMD = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_R48 = 3'd1;
	localparam logic [2:0] KIND_R48B = 3'd2;
	localparam logic [2:0] KIND_R136 = 3'd3;
	localparam logic [2:0] KIND_DATA = 3'd4;

	localparam logic [1:0] DST_OK = 2'd0;
	localparam logic [1:0] DST_STATE = 2'd1;
	localparam logic [1:0] DST_SIZE = 2'd2;

	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_READ = 2'd1;
	localparam logic [1:0] ACC_WRITE = 2'd2;

	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_ALL_CID = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA = 6'd3;
	localparam logic [5:0] CMD_SWITCH = 6'd6;
	localparam logic [5:0] CMD_SELECT = 6'd7;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD = 6'd9;
	localparam logic [5:0] CMD_SEND_CID = 6'd10;
	localparam logic [5:0] CMD_STOP = 6'd12;
	localparam logic [5:0] CMD_STATUS = 6'd13;
	localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
	localparam logic [5:0] CMD_READ_ONE = 6'd17;
	localparam logic [5:0] CMD_READ_MULTI = 6'd18;
	localparam logic [5:0] CMD_BLOCK_COUNT = 6'd23;
	localparam logic [5:0] CMD_WRITE_ONE = 6'd24;
	localparam logic [5:0] CMD_WRITE_MULTI = 6'd25;
	localparam logic [5:0] CMD_OP_COND = 6'd41;
	localparam logic [5:0] CMD_SEND_SCR = 6'd51;
	localparam logic [5:0] CMD_APP = 6'd55;

	localparam logic [31:0] ERR_STATE = 32'h0040_0000;
	localparam logic [31:0] ERR_PARAM = 32'h8000_0000;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_READY = 9'b000000010,
		ST_IDENT = 9'b000000100,
		ST_STBY  = 9'b000001000,
		ST_TRAN  = 9'b000010000,
		ST_DATA  = 9'b000100000,
		ST_RCV   = 9'b001000000,
		ST_PRG   = 9'b010000000,
		ST_DIS   = 9'b100000000
	} card_st_t;

	typedef struct packed {
		logic [11:0] cs;
		logic [2:0]  mult;
		logic [4:0]  bl;
	} csd_v1_t;

	typedef struct packed {
		logic        hc;
		csd_v1_t     v1;
		logic [23:0] hc_cs;
	} geom_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [1:0]        status;
		logic [1:0]        access;
		logic [31:0]       sector;
		logic [4:0]        count;
		logic              crc_en;
		logic [16:0][7:0]  bytes;
	} reply_t;

	function automatic logic [3:0] st_code(input card_st_t s);
		logic [3:0] c;
		case (s)
			ST_IDLE:  c = 4'd0;
			ST_READY: c = 4'd1;
			ST_IDENT: c = 4'd2;
			ST_STBY:  c = 4'd3;
			ST_TRAN:  c = 4'd4;
			ST_DATA:  c = 4'd5;
			ST_RCV:   c = 4'd6;
			ST_PRG:   c = 4'd7;
			ST_DIS:   c = 4'd8;
			default:  c = 4'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) c = {c[6:0], 1'b0} ^ 8'h12;
			else c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic csd_v1_t csd_v1(input logic [31:0] n);
		csd_v1_t r;
		logic [32:0] ceil_v;
		logic [32:0] sel_ceil;
		logic [31:0] mask;
		logic [4:0] sel;
		logic [4:0] shr;
		logic [4:0] rest;
		logic [2:0] mult;
		logic [11:0] cs;
		sel = 5'd31;
		sel_ceil = '0;
		for (int sh = 31; sh >= 2; sh--) begin
			mask = (32'd1 << sh) - 32'd1;
			ceil_v = {1'b0, n >> sh} + {32'd0, |(n & mask)};
			if (ceil_v <= 33'd4096) begin
				sel = 5'(sh);
				sel_ceil = ceil_v;
			end
		end
		cs = sel_ceil[11:0] - 12'd1;
		shr = sel - 5'd2;
		mult = (shr > 5'd7) ? 3'd7 : shr[2:0];
		rest = shr - {2'b00, mult};
		if (rest > 5'd1) cs = '0;
		r.cs = cs;
		r.mult = mult;
		r.bl = rest + 5'd9;
		return r;
	endfunction

	function automatic geom_t card_geom(input logic [31:0] n);
		geom_t g;
		logic [32:0] t;
		t = {1'b0, n} + 33'd1023;
		g.hc = n > HC_LIMIT;
		g.v1 = csd_v1(n);
		g.hc_cs = {1'b0, t[32:10]} - 24'd1;
		return g;
	endfunction

endpackage

@@ sv/sdcr_decode.sv @@
// Card state and per-item decode: builds the whole reply of one item.
// Uses sdcr_pkg; state advances on the load pulse from the top level.
module sdcr_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [1:0]       action,
	input  logic [5:0]       cmd_index,
	input  logic [31:0]      argument,
	input  logic [12:0]      block_size,
	input  sdcr_pkg::geom_t  geom,
	output sdcr_pkg::reply_t reply
);
	import sdcr_pkg::*;

	card_st_t    state_q, state_n;
	logic        app_q, app_n;
	logic        rep_q, rep_n;
	logic [15:0] rel_q, rel_n;
	logic [4:0]  polls_q, polls_n;
	logic [31:0] first_q, first_n;
	logic [31:0] cur_q, cur_n;
	logic        bufsec_q, bufsec_n;
	logic        multi_q, multi_n;
	logic [9:0]  explen_q, explen_n;
	logic        cntv_q, cntv_n;
	logic [31:0] blocks_q, blocks_n;

	always_comb begin
		logic       was_app, put, rca, bad, badp, nocrc, low24, xfer, xmulti;
		logic [31:0] r1w;
		card_st_t   xnext;
		state_n = state_q;
		app_n = app_q;
		rep_n = rep_q;
		rel_n = rel_q;
		polls_n = polls_q;
		first_n = first_q;
		cur_n = cur_q;
		bufsec_n = bufsec_q;
		multi_n = multi_q;
		explen_n = explen_q;
		cntv_n = cntv_q;
		blocks_n = blocks_q;
		reply = '0;
		reply.count = 5'd1;
		put = 1'b0;
		rca = 1'b0;
		bad = 1'b0;
		badp = 1'b0;
		nocrc = 1'b0;
		xfer = 1'b0;
		xmulti = 1'b0;
		xnext = ST_DATA;
		low24 = argument[23:0] != 24'd0;
		was_app = app_q;
		r1w = '0;

		if (action == ACT_CMD) begin
			app_n = 1'b0;
			reply.bytes[0] = {2'b00, cmd_index};
			case (cmd_index)
				CMD_GO_IDLE: begin
					state_n = ST_IDLE;
					rep_n = 1'b0;
					rel_n = '0;
					first_n = '0;
					polls_n = INIT_POLLS;
				end
				CMD_ALL_CID, CMD_SEND_CID: begin
					if (state_q != ((cmd_index == CMD_ALL_CID) ? ST_READY : ST_STBY)) begin
						bad = 1'b1;
					end else begin
						if (cmd_index == CMD_ALL_CID) state_n = ST_IDENT;
						reply.kind = KIND_R136;
						reply.bytes[15:1] = {8'h14, 8'h03, 8'hEC, 8'h4A, 8'h00, 8'h00, 8'h20,
							8'h20, 8'h44, 8'h53, 8'h76, 8'h20, 8'h72, 8'h47, 8'h44};
					end
				end
				CMD_SEND_RCA: begin
					if (state_q != ST_IDENT && state_q != ST_STBY) begin
						bad = 1'b1;
					end else begin
						state_n = ST_STBY;
						rel_n = RCA_VALUE;
						rca = 1'b1;
						reply.kind = KIND_R48;
					end
				end
				CMD_SWITCH: begin
					if (state_q != ST_TRAN) bad = 1'b1;
					else if (was_app) put = 1'b1;
				end
				CMD_SELECT: begin
					if (state_q == ST_STBY && rel_q == argument[31:16]) begin
						state_n = ST_TRAN;
						put = 1'b1;
						reply.kind = KIND_R48B;
					end else if ((state_q == ST_STBY || state_q == ST_TRAN ||
						state_q == ST_DATA || state_q == ST_PRG) &&
						rel_q != argument[31:16]) begin
						state_n = ST_STBY;
						put = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				CMD_IF_COND: begin
					if (state_q != ST_IDLE) bad = 1'b1;
					else if (argument[31:8] != 24'd1) badp = 1'b1;
					else begin
						reply.kind = KIND_R48;
						reply.bytes[3] = 8'h01;
						reply.bytes[4] = argument[7:0];
					end
				end
				CMD_SEND_CSD: begin
					if (state_q != ST_STBY) begin
						bad = 1'b1;
					end else begin
						reply.kind = KIND_R136;
						if (geom.hc) begin
							reply.bytes[15:1] = {8'h00, 8'h40, 8'h0A, 8'h80, 8'h0F,
								geom.hc_cs[7:0], geom.hc_cs[15:8], geom.hc_cs[23:16],
								8'h00, 8'h59, 8'h5B, 8'h5A, 8'h00, 8'h0e, 8'h40};
						end else begin
							reply.bytes[15:1] = {8'h00,
								{geom.v1.bl[1:0], 6'd0},
								8'h08 | {5'd0, geom.v1.bl[4:2]},
								8'h80,
								8'h0F | {geom.v1.mult[0], 7'd0},
								8'hD8 | {6'd0, geom.v1.mult[2:1]},
								{geom.v1.cs[1:0], 6'h2D},
								geom.v1.cs[9:2],
								8'h80 | {6'd0, geom.v1.cs[11:10]},
								8'h50 | {3'd0, geom.v1.bl},
								8'h5B, 8'h5A, 8'h00, 8'h0e, 8'h00};
						end
					end
				end
				CMD_STOP: begin
					if (state_q != ST_DATA && state_q != ST_RCV) bad = 1'b1;
					else begin
						state_n = ST_TRAN;
						put = 1'b1;
					end
				end
				CMD_STATUS: begin
					if (was_app || st_code(state_q) < 4'd3) bad = 1'b1;
					else put = 1'b1;
				end
				CMD_BLOCKLEN: begin
					if (was_app || state_q != ST_TRAN) bad = 1'b1;
					else if (argument != 32'd512) badp = 1'b1;
					else put = 1'b1;
				end
				CMD_READ_ONE, CMD_READ_MULTI, CMD_WRITE_ONE, CMD_WRITE_MULTI: begin
					if (cmd_index == CMD_READ_ONE || cmd_index == CMD_WRITE_ONE) cntv_n = 1'b0;
					xmulti = cmd_index == CMD_READ_MULTI || cmd_index == CMD_WRITE_MULTI;
					xnext = (cmd_index == CMD_READ_ONE || cmd_index == CMD_READ_MULTI) ?
						ST_DATA : ST_RCV;
					xfer = 1'b1;
				end
				CMD_BLOCK_COUNT: begin
					if (state_q != ST_TRAN) bad = 1'b1;
					else begin
						if (!was_app) begin
							cntv_n = argument != 32'd0;
							blocks_n = argument;
						end
						put = 1'b1;
					end
				end
				CMD_OP_COND: begin
					if (was_app) begin
						if (state_q != ST_IDLE) begin
							bad = 1'b1;
						end else begin
							rep_n = 1'b1;
							if (!low24 && first_q != 32'd0) badp = 1'b1;
							else if (low24 && first_q != 32'd0 && first_q != argument) badp = 1'b1;
							else begin
								if (low24 && first_q == 32'd0) first_n = argument;
								reply.kind = KIND_R48;
								nocrc = 1'b1;
								reply.bytes[0] = 8'h3f;
								reply.bytes[2] = 8'hff;
								reply.bytes[3] = 8'h80;
								reply.bytes[5] = 8'hff;
								if (low24) begin
									if (polls_q != 5'd0) begin
										polls_n = polls_q - 5'd1;
									end else if (argument[30] || !geom.hc) begin
										reply.bytes[1] = {1'b1, geom.hc, 6'd0};
										state_n = ST_READY;
									end
								end
							end
						end
					end
				end
				CMD_SEND_SCR: begin
					if (was_app) begin
						if (state_q != ST_TRAN) bad = 1'b1;
						else begin
							bufsec_n = 1'b0;
							explen_n = 10'd8;
							state_n = ST_DATA;
							put = 1'b1;
						end
					end
				end
				CMD_APP: begin
					if (state_q == ST_READY || state_q == ST_IDENT) bad = 1'b1;
					else if (argument[31:16] != rel_q) badp = 1'b1;
					else begin
						app_n = 1'b1;
						put = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (xfer) begin
				if (was_app || state_q != ST_TRAN) bad = 1'b1;
				else if (!geom.hc && argument[8:0] != 9'd0) badp = 1'b1;
				else begin
					cur_n = geom.hc ? argument : {9'd0, argument[31:9]};
					state_n = xnext;
					bufsec_n = 1'b1;
					multi_n = xmulti;
					explen_n = 10'd512;
					put = 1'b1;
				end
			end

			r1w = 32'h0000_0100 | {19'd0, st_code(state_n), 9'd0} |
				{26'd0, app_n || rep_n, 5'd0} |
				(bad ? ERR_STATE : 32'd0) | (badp ? ERR_PARAM : 32'd0);
			if (bad || badp) put = 1'b1;
			if (put || rca) rep_n = 1'b0;
			if (put) begin
				if (reply.kind == KIND_NONE) reply.kind = KIND_R48;
				reply.bytes[1] = r1w[31:24];
				reply.bytes[2] = r1w[23:16];
				reply.bytes[3] = r1w[15:8];
				reply.bytes[4] = r1w[7:0];
			end
			if (rca) begin
				reply.bytes[1] = RCA_VALUE[15:8];
				reply.bytes[2] = RCA_VALUE[7:0];
				reply.bytes[3] = {r1w[23:22], r1w[19], r1w[12:8]};
				reply.bytes[4] = r1w[7:0];
			end
			if (reply.kind == KIND_R136) reply.count = 5'd17;
			else if (reply.kind != KIND_NONE) reply.count = 5'd6;
			else reply.bytes = '0;
			reply.crc_en = reply.kind != KIND_NONE && !nocrc;
		end else if (action == ACT_WRITE || action == ACT_READ) begin
			reply.kind = KIND_DATA;
			if (state_q != ((action == ACT_WRITE) ? ST_RCV : ST_DATA)) begin
				reply.status = DST_STATE;
			end else if (block_size != {3'd0, explen_q}) begin
				reply.status = DST_SIZE;
			end else if (bufsec_q) begin
				if (cntv_q) begin
					blocks_n = blocks_q - 32'd1;
					if (blocks_n == 32'd0) multi_n = 1'b0;
				end
				if (multi_n) cur_n = cur_q + 32'd1;
				else state_n = ST_TRAN;
				reply.access = (action == ACT_WRITE) ? ACC_WRITE : ACC_READ;
				reply.sector = cur_q;
			end else if (action == ACT_WRITE) begin
				reply.status = DST_STATE;
			end else begin
				state_n = ST_TRAN;
				reply.count = 5'd8;
				reply.bytes[0] = geom.hc ? 8'h02 : 8'h01;
				reply.bytes[1] = 8'h05;
				reply.bytes[3] = 8'h03;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			app_q <= 1'b0;
			rep_q <= 1'b0;
			rel_q <= '0;
			polls_q <= INIT_POLLS;
			first_q <= '0;
			cur_q <= '0;
			bufsec_q <= 1'b0;
			multi_q <= 1'b0;
			explen_q <= '0;
			cntv_q <= 1'b0;
			blocks_q <= '0;
		end else if (load) begin
			state_q <= state_n;
			app_q <= app_n;
			rep_q <= rep_n;
			rel_q <= rel_n;
			polls_q <= polls_n;
			first_q <= first_n;
			cur_q <= cur_n;
			bufsec_q <= bufsec_n;
			multi_q <= multi_n;
			explen_q <= explen_n;
			cntv_q <= cntv_n;
			blocks_q <= blocks_n;
		end
	end

endmodule

@@ sv/sdcr_emit.sv @@
// Result register and byte serializer: shifts out one reply byte per beat.
// Uses sdcr_pkg; appends the running CRC7 as the last byte when enabled.
module sdcr_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sdcr_pkg::reply_t reply,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,  // reply_byte, data_status, store_access, sector_number
	output logic [2:0]       m_tuser,  // reply_kind
	output logic             m_tlast
);
	import sdcr_pkg::*;

	logic [16:0][7:0] bytes_q;
	logic [4:0]       cnt_q;
	logic [7:0]       crc_q;
	logic             crc_en_q;
	logic [2:0]       kind_q;
	logic [1:0]       status_q;
	logic [1:0]       access_q;
	logic [31:0]      sector_q;
	logic [7:0]       byte_out;
	logic             beat;

	assign m_tvalid = cnt_q != 5'd0;
	assign m_tlast = cnt_q == 5'd1;
	assign beat = m_tvalid && m_tready;
	assign free = !m_tvalid || (beat && m_tlast);
	assign byte_out = (m_tlast && crc_en_q) ? (crc_q | 8'h01) : bytes_q[0];
	assign m_tdata = {4'd0, sector_q, access_q, status_q, byte_out};
	assign m_tuser = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= reply.count;
		end else if (beat) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= reply.bytes;
			crc_q <= '0;
			crc_en_q <= reply.crc_en;
			kind_q <= reply.kind;
			status_q <= reply.status;
			access_q <= reply.access;
			sector_q <= reply.sector;
		end else if (beat) begin
			bytes_q <= {8'd0, bytes_q[16:1]};
			crc_q <= crc7_byte(crc_q, bytes_q[0]);
		end
	end

endmodule

@@ sv/sd_card_command_responder.sv @@
// Top level of the SD card command responder: input register, capacity
// register, decode and serializer. Depends on sdcr_pkg, sdcr_decode, sdcr_emit.
//
// channel | direction | beat carries
// s_*     | in        | tuser action; tdata cmd_index, argument, block_size
// m_*     | out       | tuser reply_kind; tdata reply bytes and store request; tlast
// cfg_*   | in        | card_sectors
//
// An item is decoded from the input register once the serializer is free and yields
// 1, 6, 8 or 17 result beats, one per cycle while m_tready is high; the serializer sets
// the rate. The next item waits in the input register while results drain.
// Reset is asynchronous, active low; no clearing pass.
module sd_card_command_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // cmd_index, argument, block_size
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // reply_byte, data_status, store_access, sector_number
	output logic [2:0]  m_tuser,   // reply_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // card_sectors
);
	import sdcr_pkg::*;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [5:0]  cmd_s1;
	logic [31:0] arg_s1;
	logic [12:0] bsz_s1;
	geom_t       geom_q;
	reply_t      reply;
	logic        free;
	logic        load;

	assign cfg_ready = 1'b1;
	assign load = valid_s1 && free;
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			geom_q <= card_geom(CARD_SECTORS_RST);
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (cfg_valid) geom_q <= card_geom(cfg_data);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			cmd_s1 <= s_tdata[5:0];
			arg_s1 <= s_tdata[37:6];
			bsz_s1 <= s_tdata[50:38];
		end
	end

	sdcr_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.action     (action_s1),
		.cmd_index  (cmd_s1),
		.argument   (arg_s1),
		.block_size (bsz_s1),
		.geom       (geom_q),
		.reply      (reply)
	);

	sdcr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.reply    (reply),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded reply not presented");
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load |-> !s_tready)
		else $error("input taken while register occupied");
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !load |=> !m_tvalid)
		else $error("beats continue past last");
`endif

endmodule

@@ verif/sdcr_checker.sv @@
// Checker for the SD card command responder: watches the input, config and reply channels,
// predicts every reply beat from its own card model and compares them in order.
// Depends on sdcr_pkg for the action, kind, status, access and command codes.
module sdcr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,   // cmd_index, argument, block_size
	input  logic [1:0]  s_tuser,   // action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // reply_byte, data_status, store_access, sector_number
	input  logic [2:0]  m_tuser,   // reply_kind
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,  // card_sectors
	output int          fails,
	output int          pending
);
	import sdcr_pkg::*;

	localparam bit [3:0] CS_IDLE  = 4'd0;
	localparam bit [3:0] CS_READY = 4'd1;
	localparam bit [3:0] CS_IDENT = 4'd2;
	localparam bit [3:0] CS_STBY  = 4'd3;
	localparam bit [3:0] CS_TRAN  = 4'd4;
	localparam bit [3:0] CS_DATA  = 4'd5;
	localparam bit [3:0] CS_RCV   = 4'd6;
	localparam bit [3:0] CS_PRG   = 4'd7;
	localparam bit [3:0] CS_DIS   = 4'd8;

	typedef struct packed {
		bit [2:0]  kind;
		bit [7:0]  rbyte;
		bit [1:0]  dst;
		bit [1:0]  acc;
		bit [31:0] sec;
		bit        lst;
	} reply_beat_t;

	reply_beat_t reply_q[$];

	bit [31:0] sectors;
	bit [3:0]  cst;
	bit        app_pend;
	bit        rep_app;
	bit [15:0] rca;
	bit [4:0]  polls;
	bit [31:0] first_arg;
	bit [31:0] cur_sec;
	bit        buf_sec;
	bit        multi;
	bit [12:0] want_len;
	bit        cnt_valid;
	bit [31:0] blocks_left;
	bit [7:0]  rb [17];

	assign pending = reply_q.size();

	function automatic bit high_cap();
		return sectors > 32'd4194304;
	endfunction

	function automatic void reset_card();
		sectors = CARD_SECTORS_RST;
		cst = CS_IDLE;
		app_pend = 0;
		rep_app = 0;
		rca = 0;
		polls = INIT_POLLS;
		first_arg = 0;
		cur_sec = 0;
		buf_sec = 0;
		multi = 0;
		want_len = 0;
		cnt_valid = 0;
		blocks_left = 0;
		reply_q.delete();
	endfunction

	function automatic bit [7:0] crc_over(int n);
		bit [7:0] c;
		c = 0;
		for (int i = 0; i < n; i++) begin
			c ^= rb[i];
			for (int k = 0; k < 8; k++)
				c = c[7] ? ({c[6:0], 1'b0} ^ 8'h12) : {c[6:0], 1'b0};
		end
		return c | 8'h01;
	endfunction

	function automatic bit [31:0] status_word(bit [31:0] orr);
		bit [31:0] r;
		r = 32'h100 | (32'(cst) << 9);
		if (app_pend || rep_app) r |= 32'h20;
		rep_app = 0;
		return r | orr;
	endfunction

	function automatic bit [2:0] put_status(bit [31:0] orr);
		bit [31:0] r;
		r = status_word(orr);
		rb[1] = r[31:24];
		rb[2] = r[23:16];
		rb[3] = r[15:8];
		rb[4] = r[7:0];
		return KIND_R48;
	endfunction

	function automatic void put_cid();
		bit [7:0] cid [15];
		cid = '{8'h44, 8'h47, 8'h72, 8'h20, 8'h76, 8'h53, 8'h44, 8'h20, 8'd32, 8'h00, 8'h00,
			8'h4A, 8'hEC, 8'd3, 8'd20};
		for (int i = 0; i < 15; i++) rb[i + 1] = cid[i];
	endfunction

	function automatic void put_csd();
		bit [63:0] t;
		bit [31:0] n, sh, mult, cs, bl;
		if (high_cap()) begin
			t = ((64'(sectors) + 64'd1023) >> 10) - 64'd1;
			cs = t[31:0];
			rb[1] = 8'h40; rb[2] = 8'h0e; rb[3] = 8'h00; rb[4] = 8'h5A;
			rb[5] = 8'h5B; rb[6] = 8'h59; rb[7] = 8'h00;
			rb[8] = cs[23:16]; rb[9] = cs[15:8]; rb[10] = cs[7:0];
			rb[11] = 8'h0F; rb[12] = 8'h80; rb[13] = 8'h0A; rb[14] = 8'h40; rb[15] = 8'h00;
		end else begin
			n = sectors;
			sh = 0;
			while (n > 32'h1000 || sh < 2) begin
				if (n[0]) n = n + 1;
				n = n >> 1;
				sh++;
			end
			cs = (n - 1) & 32'hFFF;
			sh -= 2;
			mult = sh > 7 ? 7 : sh;
			sh -= mult;
			if (sh > 1) cs = 0;
			bl = sh + 9;
			rb[1] = 8'h00; rb[2] = 8'h0e; rb[3] = 8'h00; rb[4] = 8'h5A; rb[5] = 8'h5B;
			rb[6] = 8'(bl | 32'h50);
			rb[7] = 8'((cs >> 10) | 32'h80);
			rb[8] = 8'(cs >> 2);
			rb[9] = 8'((cs << 6) | 32'h2D);
			rb[10] = 8'((mult >> 1) | 32'hD8);
			rb[11] = 8'(32'h0F | ((mult & 1) << 7));
			rb[12] = 8'h80;
			rb[13] = 8'((bl >> 2) | 32'h8);
			rb[14] = 8'(bl << 6);
			rb[15] = 8'h00;
		end
	endfunction

	function automatic bit [2:0] start_xfer(bit was_app, bit [31:0] arg, bit [3:0] nxt, bit mb);
		if (was_app || cst != CS_TRAN) return put_status(ERR_STATE);
		if (!high_cap() && arg[8:0] != 0) return put_status(ERR_PARAM);
		cur_sec = high_cap() ? arg : (arg >> 9);
		cst = nxt;
		buf_sec = 1;
		multi = mb;
		want_len = 13'd512;
		return put_status(0);
	endfunction

	function automatic bit [2:0] run_cmd(bit [5:0] cmd, bit [31:0] arg, output bit no_crc);
		bit was_app;
		bit [31:0] r;
		was_app = app_pend;
		app_pend = 0;
		no_crc = 0;
		case (cmd)
			CMD_GO_IDLE: begin
				cst = CS_IDLE;
				rep_app = 0;
				rca = 0;
				first_arg = 0;
				polls = INIT_POLLS;
				return KIND_NONE;
			end
			CMD_ALL_CID: begin
				if (cst != CS_READY) return put_status(ERR_STATE);
				cst = CS_IDENT;
				put_cid();
				return KIND_R136;
			end
			CMD_SEND_CID: begin
				if (cst != CS_STBY) return put_status(ERR_STATE);
				put_cid();
				return KIND_R136;
			end
			CMD_SEND_RCA: begin
				if (cst != CS_IDENT && cst != CS_STBY) return put_status(ERR_STATE);
				cst = CS_STBY;
				rca = RCA_VALUE;
				r = status_word(0);
				rb[1] = rca[15:8];
				rb[2] = rca[7:0];
				rb[3] = {r[23:22], r[19], r[12:8]};
				rb[4] = r[7:0];
				return KIND_R48;
			end
			CMD_SWITCH: begin
				if (cst != CS_TRAN) return put_status(ERR_STATE);
				return was_app ? put_status(0) : KIND_NONE;
			end
			CMD_SELECT: begin
				if (cst == CS_STBY && rca == arg[31:16]) begin
					cst = CS_TRAN;
					void'(put_status(0));
					return KIND_R48B;
				end
				if ((cst == CS_STBY || cst == CS_TRAN || cst == CS_DATA || cst == CS_PRG)
						&& rca != arg[31:16]) begin
					cst = CS_STBY;
					return put_status(0);
				end
				return put_status(ERR_STATE);
			end
			CMD_IF_COND: begin
				if (cst != CS_IDLE) return put_status(ERR_STATE);
				if ((arg & 32'hffffff00) != 32'h100) return put_status(ERR_PARAM);
				rb[1] = 0; rb[2] = 0; rb[3] = 1; rb[4] = arg[7:0];
				return KIND_R48;
			end
			CMD_SEND_CSD: begin
				if (cst != CS_STBY) return put_status(ERR_STATE);
				put_csd();
				return KIND_R136;
			end
			CMD_STOP: begin
				if (cst != CS_DATA && cst != CS_RCV) return put_status(ERR_STATE);
				cst = CS_TRAN;
				return put_status(0);
			end
			CMD_STATUS: begin
				if (was_app || cst < CS_STBY || cst > CS_DIS) return put_status(ERR_STATE);
				return put_status(0);
			end
			CMD_BLOCKLEN: begin
				if (was_app || cst != CS_TRAN) return put_status(ERR_STATE);
				if (arg != 512) return put_status(ERR_PARAM);
				return put_status(0);
			end
			CMD_READ_ONE: begin
				cnt_valid = 0;
				return start_xfer(was_app, arg, CS_DATA, 0);
			end
			CMD_READ_MULTI: return start_xfer(was_app, arg, CS_DATA, 1);
			CMD_BLOCK_COUNT: begin
				if (cst != CS_TRAN) return put_status(ERR_STATE);
				if (!was_app) begin
					cnt_valid = arg != 0;
					blocks_left = arg;
				end
				return put_status(0);
			end
			CMD_WRITE_ONE: begin
				cnt_valid = 0;
				return start_xfer(was_app, arg, CS_RCV, 0);
			end
			CMD_WRITE_MULTI: return start_xfer(was_app, arg, CS_RCV, 1);
			CMD_OP_COND: begin
				if (!was_app) return KIND_NONE;
				if (cst != CS_IDLE) return put_status(ERR_STATE);
				rep_app = 1;
				if (arg[23:0] == 0) begin
					if (first_arg != 0) return put_status(ERR_PARAM);
				end else begin
					if (first_arg == 0) first_arg = arg;
					else if (first_arg != arg) return put_status(ERR_PARAM);
				end
				rb[0] = 8'h3f; rb[1] = 8'h00; rb[2] = 8'hff; rb[3] = 8'h80; rb[4] = 8'h00;
				rb[5] = 8'hff;
				no_crc = 1;
				if (arg[23:0] != 0) begin
					if (polls != 0) polls--;
					else if (!(!arg[30] && high_cap())) begin
						if (high_cap()) rb[1] |= 8'h40;
						rb[1] |= 8'h80;
						cst = CS_READY;
					end
				end
				return KIND_R48;
			end
			CMD_SEND_SCR: begin
				if (!was_app) return KIND_NONE;
				if (cst != CS_TRAN) return put_status(ERR_STATE);
				buf_sec = 0;
				want_len = 13'd8;
				cst = CS_DATA;
				return put_status(0);
			end
			CMD_APP: begin
				if (cst == CS_READY || cst == CS_IDENT) return put_status(ERR_STATE);
				if (arg[31:16] != rca) return put_status(ERR_PARAM);
				app_pend = 1;
				return put_status(0);
			end
			default: return KIND_NONE;
		endcase
	endfunction

	function automatic void push_beat(bit [2:0] kind, bit [7:0] b, bit [1:0] dst, bit [1:0] acc,
			bit [31:0] sec, bit lst);
		reply_q.push_back('{kind, b, dst, acc, sec, lst});
	endfunction

	function automatic void predict_item(bit [1:0] action, bit [5:0] cmd, bit [31:0] arg,
			bit [12:0] bsz);
		bit [2:0] kind;
		bit no_crc;
		bit [3:0] need;
		bit [31:0] sec;
		int len;
		if (action == ACT_CMD) begin
			foreach (rb[i]) rb[i] = 0;
			rb[0] = {2'b00, cmd};
			kind = run_cmd(cmd, arg, no_crc);
			if (kind == KIND_NONE) begin
				push_beat(KIND_NONE, 0, 0, 0, 0, 1);
				return;
			end
			len = (kind == KIND_R136) ? 17 : 6;
			if (!no_crc) rb[len - 1] = crc_over(len - 1);
			for (int i = 0; i < len; i++) push_beat(kind, rb[i], 0, 0, 0, i == len - 1);
		end else if (action == ACT_WRITE || action == ACT_READ) begin
			need = (action == ACT_WRITE) ? CS_RCV : CS_DATA;
			if (cst != need) push_beat(KIND_DATA, 0, DST_STATE, ACC_NONE, 0, 1);
			else if (bsz != want_len) push_beat(KIND_DATA, 0, DST_SIZE, ACC_NONE, 0, 1);
			else if (buf_sec) begin
				sec = cur_sec;
				if (cnt_valid) begin
					blocks_left--;
					if (blocks_left == 0) multi = 0;
				end
				if (multi) cur_sec++;
				else cst = CS_TRAN;
				push_beat(KIND_DATA, 0, DST_OK, (action == ACT_WRITE) ? ACC_WRITE : ACC_READ,
					sec, 1);
			end else if (action == ACT_WRITE) begin
				push_beat(KIND_DATA, 0, DST_STATE, ACC_NONE, 0, 1);
			end else begin
				cst = CS_TRAN;
				push_beat(KIND_DATA, high_cap() ? 8'h02 : 8'h01, DST_OK, ACC_NONE, 0, 0);
				push_beat(KIND_DATA, 8'h05, DST_OK, ACC_NONE, 0, 0);
				push_beat(KIND_DATA, 8'h00, DST_OK, ACC_NONE, 0, 0);
				push_beat(KIND_DATA, 8'h03, DST_OK, ACC_NONE, 0, 0);
				for (int i = 4; i < 8; i++) push_beat(KIND_DATA, 0, DST_OK, ACC_NONE, 0, i == 7);
			end
		end else begin
			push_beat(KIND_NONE, 0, 0, 0, 0, 1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_beat_t exp_b, got;
		if (!arst_n) begin
			reset_card();
			fails <= 0;
		end else begin
			if (cfg_valid && cfg_ready) sectors = cfg_data;
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata[5:0], s_tdata[37:6], s_tdata[50:38]);
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[11:10], m_tdata[43:12],
					m_tlast};
				if (reply_q.size() == 0) begin
					$display("%0t: unexpected reply beat %p", $time, got);
					fails <= fails + 1;
				end else begin
					exp_b = reply_q.pop_front();
					if (got.kind != exp_b.kind || got.rbyte != exp_b.rbyte ||
							got.dst != exp_b.dst || got.acc != exp_b.acc ||
							got.sec != exp_b.sec || got.lst != exp_b.lst) begin
						$display("%0t: reply mismatch expected %p actual %p", $time, exp_b, got);
						fails <= fails + 1;
					end
				end
			end
		end
	end

endmodule

@@ verif/sd_card_command_responder_tb.sv @@
// Testbench top for the SD card command responder: clock, reset, card bring-up sequences,
// random command and data traffic over several capacities, and the verdict.
// Depends on sdcr_pkg, sd_card_command_responder and sdcr_checker.
module sd_card_command_responder_tb;
	import sdcr_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // cmd_index, argument, block_size
	logic [1:0]  s_tuser = '0;   // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // reply_byte, data_status, store_access, sector_number
	logic [2:0]  m_tuser;        // reply_kind
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;  // card_sectors
	int          fails;
	int          pending;
	int          cycles = 0;
	bit          hold = 0;
	bit          burst = 0;

	sd_card_command_responder i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	sdcr_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int gap;
		forever begin
			gap = burst ? 0 : $urandom_range(0, 5);
			if (gap > 0 || hold) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send(logic [1:0] action, logic [5:0] cmd, logic [31:0] arg, logic [12:0] bsz);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= {5'd0, bsz, arg, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic set_capacity(logic [31:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic bring_up();
		send(ACT_CMD, CMD_GO_IDLE, 0, 0);
		send(ACT_CMD, CMD_IF_COND, 32'h1AA, 0);
		repeat (21) begin
			send(ACT_CMD, CMD_APP, 0, 0);
			send(ACT_CMD, CMD_OP_COND, 32'h40FF8000, 0);
		end
		send(ACT_CMD, CMD_ALL_CID, 0, 0);
		send(ACT_CMD, CMD_SEND_RCA, 0, 0);
		send(ACT_CMD, CMD_SEND_CSD, 32'h30000, 0);
		send(ACT_CMD, CMD_SEND_CID, 32'h30000, 0);
		send(ACT_CMD, CMD_SELECT, 32'h30000, 0);
	endtask

	task automatic requery();
		send(ACT_CMD, CMD_SELECT, 0, 0);
		send(ACT_CMD, CMD_SEND_CSD, 32'h30000, 0);
		send(ACT_CMD, CMD_SELECT, 32'h30000, 0);
	endtask

	task automatic random_ops(int n);
		logic [5:0] cmds [15];
		logic [31:0] arg;
		logic [12:0] bsz;
		int r;
		cmds = '{CMD_SELECT, CMD_IF_COND, CMD_STOP, CMD_STATUS, CMD_BLOCKLEN, CMD_READ_ONE,
			CMD_READ_MULTI, CMD_BLOCK_COUNT, CMD_WRITE_ONE, CMD_WRITE_MULTI, CMD_OP_COND,
			CMD_SEND_SCR, CMD_APP, CMD_SWITCH, CMD_SEND_CSD};
		repeat (n) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: arg = $urandom;
				1: arg = 32'h30000;
				2: arg = $urandom_range(0, 7) << 9;
				default: arg = $urandom_range(0, 3);
			endcase
			case ($urandom_range(0, 4))
				0: bsz = 13'($urandom_range(0, 4096));
				1: bsz = 13'd8;
				default: bsz = 13'd512;
			endcase
			if (r < 45) send(2'($urandom_range(1, 2)), 6'($urandom), $urandom, bsz);
			else if (r < 47) send(2'd3, 6'($urandom), $urandom, 13'($urandom_range(0, 4096)));
			else if (r < 50) send(ACT_CMD, 6'($urandom), arg, 0);
			else if (r < 52) send(ACT_CMD, CMD_GO_IDLE, arg, 0);
			else send(ACT_CMD, cmds[$urandom_range(0, 14)], arg, 0);
		end
	endtask

	initial begin
		logic [31:0] caps [6];
		caps = '{32'd1048576, 32'd0, 32'd4194304, 32'd4194305, 32'hFFFFFFFF, 32'd0};
		caps[5] = $urandom_range(1, 4194304);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bring_up();
		send(ACT_CMD, CMD_BLOCKLEN, 512, 0);
		send(ACT_CMD, CMD_BLOCKLEN, 513, 0);
		send(ACT_CMD, CMD_SWITCH, 0, 0);
		send(ACT_CMD, CMD_APP, 32'h30000, 0);
		send(ACT_CMD, CMD_SWITCH, 0, 0);
		send(ACT_CMD, CMD_READ_ONE, 32'h201, 0);
		send(ACT_CMD, CMD_READ_ONE, 32'h400, 0);
		send(ACT_READ, 0, 0, 511);
		send(ACT_READ, 0, 0, 512);
		send(ACT_CMD, CMD_BLOCK_COUNT, 2, 0);
		send(ACT_CMD, CMD_WRITE_MULTI, 32'hFFFFFE00, 0);
		send(ACT_WRITE, 0, 0, 512);
		send(ACT_WRITE, 0, 0, 512);
		send(ACT_CMD, CMD_READ_MULTI, 0, 0);
		send(ACT_READ, 0, 0, 512);
		send(ACT_CMD, CMD_STOP, 0, 0);
		send(ACT_CMD, CMD_APP, 32'h30000, 0);
		send(ACT_CMD, CMD_SEND_SCR, 0, 0);
		send(ACT_WRITE, 0, 0, 8);
		send(ACT_READ, 0, 0, 8);
		send(ACT_CMD, CMD_STATUS, 0, 0);
		send(ACT_CMD, CMD_SELECT, 0, 0);
		send(2'd3, 6'h3F, 32'hFFFFFFFF, 13'd4096);

		foreach (caps[p]) begin
			set_capacity(caps[p]);
			burst = (p % 2) == 1;
			if (p == 2) fork
				begin
					hold = 1;
					repeat (400) @(posedge clk);
					hold = 0;
				end
			join_none
			if (p == 1 || p == 3) bring_up();
			else requery();
			random_ops(10);
			burst = 0;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
